// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; clocked on clk, disabled in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PIU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PIU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/piu_pkg.sv
// Types, constants and helpers of the palette index unpacker.
package piu_pkg;

  localparam int PALETTE_DEPTH_DEF = 4096;
  localparam int MAX_ENTRIES_DEF   = 4096;
  localparam int WORD_BITS         = 64;
  localparam int REM_W             = $clog2(WORD_BITS + 1);

  localparam int BITS_W            = 6;
  localparam int COUNT_W           = 13;
  localparam int POS_OUT_W         = 12;
  localparam int ID_W              = 32;
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 16;

  localparam logic [BITS_W-1:0]    BITS_RESET  = 6'd4;
  localparam logic [COUNT_W-1:0]   COUNT_RESET = 13'd4096;
  localparam logic [BITS_W-1:0]    BITS_MAX    = 6'd32;

  // queue depths, powers of two
  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BITS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd1;

  typedef enum logic [1:0] {
    FN_BEGIN = 2'd0,
    FN_LOAD  = 2'd1,
    FN_DATA  = 2'd2,
    FN_PAD   = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bk_state_t;

  typedef struct packed {
    func_t                  kind;
    logic [BITS_W-1:0]      step;
    logic [WORD_BITS-1:0]   word;
    logic [ID_W-1:0]        value;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]        state_id;
    logic [POS_OUT_W-1:0]   position;
    logic                   last_of_section;
    logic                   section_empty;
  } res_t;

  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] r;
    r = b;
    if (b == '0) r = 6'd1;
    else if (b > BITS_MAX) r = BITS_MAX;
    return r;
  endfunction

endpackage

// File: rtl/core/piu_front.sv
// Input queue: accepts items, decodes the function and the field step.
module piu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    func,
  input  logic [piu_pkg::WORD_BITS-1:0] word,
  input  logic [piu_pkg::ID_W-1:0]      palette_value,
  input  logic [piu_pkg::BITS_W-1:0]    bits_per_entry,
  output logic                          cmd_valid,
  output piu_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);
  import piu_pkg::*;

  localparam int PW = $clog2(IQ_DEPTH);
  localparam int LW = $clog2(IQ_DEPTH + 1);

  cmd_t          q [IQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;
  cmd_t          dec;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    dec.kind  = func_t'(func);
    dec.step  = (dec.kind == FN_PAD) ? 6'd1 : clamp_bits(bits_per_entry);
    // pad runs as an all-zero word at one bit per field
    dec.word  = (dec.kind == FN_DATA) ? word : '0;
    dec.value = palette_value;
  end

  assign full      = (level == LW'(IQ_DEPTH));
  assign cmd_valid = (level != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) level <= level + 1'b1;
      else if (!do_push && do_pop) level <= level - 1'b1;
    end
  end

endmodule

// File: rtl/core/piu_back.sv
// Execution side: palette store, field sequencer and lookup pipeline.
module piu_back #(
  parameter int PALETTE_DEPTH = piu_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_ENTRIES   = piu_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cmd_valid,
  input  piu_pkg::cmd_t                             cmd,
  output logic                                      cmd_pop,
  input  logic [piu_pkg::COUNT_W-1:0]               entry_count,
  input  logic [$clog2(piu_pkg::OQ_DEPTH + 1)-1:0]  res_level,
  output logic                                      res_push,
  output piu_pkg::res_t                             res
);
  import piu_pkg::*;

  localparam int ADDR_W = $clog2(PALETTE_DEPTH);
  localparam int FILL_W = $clog2(PALETTE_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int LVL_W  = $clog2(OQ_DEPTH + 1);

  bk_state_t state, state_next;

  logic [ID_W-1:0]        mem [PALETTE_DEPTH];
  logic [ID_W-1:0]        rd_data;

  logic [WORD_BITS-1:0]   work;
  logic [REM_W-1:0]       rem;
  logic [BITS_W-1:0]      step;
  logic [FILL_W-1:0]      fill;
  logic [CNT_W-1:0]       pos;
  logic                   flag;

  logic                   s1_valid;
  logic [POS_OUT_W-1:0]   s1_pos;
  logic                   s1_last;
  logic                   s1_in_range;
  logic                   s1_first;

  logic [31:0]            ec32;
  logic [31:0]            eff32;
  logic [CNT_W-1:0]       eff;
  logic                   sec_done;
  logic                   room;
  logic [ID_W-1:0]        field_mask;
  logic [ID_W-1:0]        idx;
  logic                   in_range;
  logic [REM_W-1:0]       rem_after;
  logic                   issue;
  logic                   mem_we;
  logic                   is_work;
  logic [CNT_W+POS_OUT_W-1:0] pos_ext;
  logic [ID_W-1:0]        id;
  logic                   empty_now;

  always_comb begin
    ec32  = {{(32 - COUNT_W){1'b0}}, entry_count};
    eff32 = (ec32 > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : ec32;
    eff   = eff32[CNT_W-1:0];
  end

  assign sec_done   = (pos >= eff);
  assign room       = ((LVL_W + 1)'(res_level) + (LVL_W + 1)'(s1_valid))
                      < (LVL_W + 1)'(OQ_DEPTH);
  assign field_mask = ~({ID_W{1'b1}} << step);
  assign idx        = work[ID_W-1:0] & field_mask;
  assign in_range   = (idx < 32'(fill));
  assign rem_after  = rem - REM_W'(step);
  assign pos_ext    = {{POS_OUT_W{1'b0}}, pos};
  assign is_work    = (cmd.kind == FN_DATA) || (cmd.kind == FN_PAD);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && is_work) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (sec_done) state_next = ST_IDLE;
        else if (room && (rem_after < REM_W'(step))) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop = 1'b0;
    issue   = 1'b0;
    case (state)
      ST_IDLE: cmd_pop = cmd_valid;
      ST_RUN:  issue   = !sec_done && room;
      default: begin
        cmd_pop = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  assign mem_we = cmd_pop && (cmd.kind == FN_LOAD) && (fill != FILL_W'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) mem[fill[ADDR_W-1:0]] <= cmd.value;
    rd_data <= mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      pos      <= '0;
      flag     <= 1'b1;
      s1_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        case (cmd.kind)
          FN_BEGIN: begin
            fill <= '0;
            pos  <= '0;
          end
          FN_LOAD: begin
            if (mem_we) fill <= fill + 1'b1;
          end
          default: ;
        endcase
      end
      if (issue) pos <= pos + 1'b1;
      s1_valid <= issue;
      if (s1_valid) flag <= empty_now;
    end
  end

  // working word and per-entry payload need no reset
  always_ff @(posedge clk) begin
    if (cmd_pop && is_work) begin
      work <= cmd.word;
      rem  <= REM_W'(WORD_BITS);
      step <= cmd.step;
    end else if (issue) begin
      work <= work >> step;
      rem  <= rem_after;
    end
    if (issue) begin
      s1_pos      <= pos_ext[POS_OUT_W-1:0];
      s1_last     <= (pos == eff - 1'b1);
      s1_in_range <= in_range;
      s1_first    <= (pos == '0);
    end
  end

  // position zero starts a fresh all-zero run
  assign id        = s1_in_range ? rd_data : '0;
  assign empty_now = (s1_first || flag) && (id == '0);

  assign res_push            = s1_valid;
  assign res.state_id        = id;
  assign res.position        = s1_pos;
  assign res.last_of_section = s1_last;
  assign res.section_empty   = empty_now;

endmodule

// File: rtl/core/piu_result_fifo.sv
// Result queue between the lookup pipeline and the output ports.
module piu_result_fifo (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      push,
  input  piu_pkg::res_t                             din,
  input  logic                                      pop,
  output piu_pkg::res_t                             dout,
  output logic                                      empty,
  output logic [$clog2(piu_pkg::OQ_DEPTH + 1)-1:0]  level
);
  import piu_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);

  res_t          q [OQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_pop;

  assign empty  = (level == '0);
  assign dout   = q[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) level <= level + 1'b1;
      else if (!push && do_pop) level <= level - 1'b1;
    end
  end

endmodule

// File: rtl/core/palette_index_unpacker_top.sv
// Palette index unpacker: packed words in, one palette id per entry out.
// The sequencer issues one palette read per cycle while the result queue has room; it
// takes no new item from the input queue until it is done with the current data or pad item.
// Reset empties queues and counters, sets the all-zero flag and loads config 4 / 4096;
// palette contents stay undefined until loaded and there is no clearing pass.
`include "assert_macros.svh"

module palette_index_unpacker_top #(
  parameter int PALETTE_DEPTH = piu_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_ENTRIES   = piu_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      func,
  input  logic [piu_pkg::WORD_BITS-1:0]   word,
  input  logic [piu_pkg::ID_W-1:0]        palette_value,
  output logic                            empty,
  input  logic                            pop,
  output logic [piu_pkg::ID_W-1:0]        state_id,
  output logic [piu_pkg::POS_OUT_W-1:0]   position,
  output logic                            last_of_section,
  output logic                            section_empty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [piu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [piu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import piu_pkg::*;

  localparam int LVL_W = $clog2(OQ_DEPTH + 1);

  logic [BITS_W-1:0]  bits_per_entry;
  logic [COUNT_W-1:0] entry_count;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic               res_push;
  res_t               res_in;
  res_t               res_out;
  logic [LVL_W-1:0]   res_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_entry <= BITS_RESET;
      entry_count    <= COUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BITS)  bits_per_entry <= cfg_data[BITS_W-1:0];
      if (cfg_index == REG_COUNT) entry_count    <= cfg_data[COUNT_W-1:0];
    end
  end

  piu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .word           (word),
    .palette_value  (palette_value),
    .bits_per_entry (bits_per_entry),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  piu_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_ENTRIES   (MAX_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .entry_count (entry_count),
    .res_level   (res_level),
    .res_push    (res_push),
    .res         (res_in)
  );

  piu_result_fifo u_res (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty),
    .level (res_level)
  );

  assign state_id        = res_out.state_id;
  assign position        = res_out.position;
  assign last_of_section = res_out.last_of_section;
  assign section_empty   = res_out.section_empty;

  // lookup credit must keep the result queue from overflowing
  `PIU_ASSERT_IMP(a_res_room, res_push, res_level < LVL_W'(OQ_DEPTH), "result queue overflow")
  `PIU_ASSERT_IMP(a_cmd_pop, cmd_pop, cmd_valid, "command popped from empty queue")

endmodule
